// File: hw/rtl/tufp_pkg.sv
`default_nettype none

package tufp_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;

    localparam logic [VALUE_WIDTH-1:0] MAX_VAL   = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] RISKY     = MAX_VAL / 10;
    localparam logic [3:0]             TOP_DIGIT = 4'(MAX_VAL % 10);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_MID    = 3'd2,
        PH_SECOND = 3'd3,
        PH_TAIL   = 3'd4,
        PH_ERR    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tufp_digit_acc.sv
`default_nettype none

module tufp_digit_acc (
    input  wire logic [tufp_pkg::VALUE_WIDTH-1:0] acc,
    input  wire logic [3:0]                       digit,
    output logic      [tufp_pkg::VALUE_WIDTH-1:0] acc_next,
    output logic                                  fits
);
    import tufp_pkg::*;

    // times ten as shift-add, plus the digit
    assign acc_next = (acc << 3) + (acc << 1) + VALUE_WIDTH'(digit);

    assign fits = (acc < RISKY) || ((acc == RISKY) && (digit <= TOP_DIGIT));

endmodule

`default_nettype wire

// File: hw/rtl/two_uint64_decimal_field_parser.sv
`default_nettype none
// Flow: an accepted beat is captured in the input register and processed from there; a result
//   is loaded into the result register when its last beat advances and then shows on m_valid.
// Throughput: one beat per cycle, set by the combinational digit step (compare, shift-add);
//   a last beat holds only while the result register is full and m_ready is low.
// Reset: aresetn synchronous, active low; clears phase, accumulators and both valid flags.
module two_uint64_decimal_field_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [7:0]                        s_ch,
    input  wire logic                              s_ch_valid,
    input  wire logic                              s_last,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    output logic      [tufp_pkg::OUT_WIDTH-1:0]    m_first_value,
    output logic      [tufp_pkg::OUT_WIDTH-1:0]    m_second_value,
    output logic      [1:0]                        m_status,
    output logic                                   m_valid,
    input  wire logic                              m_ready
);
    import tufp_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_ch_valid_reg;
    logic       in_last_reg;
    logic       advance;

    // parse state
    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] first_acc_reg, first_acc_next;
    logic [VALUE_WIDTH-1:0] second_acc_reg, second_acc_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0] m_first_reg, m_first_next;
    logic [OUT_WIDTH-1:0] m_second_reg, m_second_next;
    status_t              m_status_reg, m_status_next;
    logic                 load_result;

    logic                   use_second;
    logic [VALUE_WIDTH-1:0] acc_sel;
    logic [VALUE_WIDTH-1:0] acc_step;
    logic                   acc_fits;
    logic                   byte_ws;
    logic                   byte_dig;
    logic                   take;

    // a last beat waits while the result register is still full and m_ready is low
    assign advance     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;
    assign load_result = advance && in_last_reg;

    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_ch_reg       <= s_ch;
            in_ch_valid_reg <= s_ch_valid;
            in_last_reg     <= s_last;
        end
    end

    assign byte_ws    = is_ws(in_ch_reg);
    assign byte_dig   = is_dig(in_ch_reg);
    assign take       = advance && in_ch_valid_reg;
    assign use_second = (phase_reg == PH_MID) || (phase_reg == PH_SECOND);
    assign acc_sel    = use_second ? second_acc_reg : first_acc_reg;

    tufp_digit_acc u_digit_acc (
        .acc      (acc_sel),
        .digit    (in_ch_reg[3:0]),
        .acc_next (acc_step),
        .fits     (acc_fits)
    );

    // next phase for the byte in the input register
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (byte_dig) begin
                        phase_next = acc_fits ? PH_FIRST : PH_ERR;
                    end else if (!byte_ws) begin
                        phase_next = PH_ERR;
                    end
                end
                PH_FIRST: begin
                    if (byte_dig) begin
                        phase_next = acc_fits ? PH_FIRST : PH_ERR;
                    end else if (byte_ws) begin
                        phase_next = PH_MID;
                    end else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_MID: begin
                    if (byte_dig) begin
                        phase_next = acc_fits ? PH_SECOND : PH_ERR;
                    end else if (!byte_ws) begin
                        phase_next = PH_ERR;
                    end
                end
                PH_SECOND: begin
                    if (byte_dig) begin
                        phase_next = acc_fits ? PH_SECOND : PH_ERR;
                    end else begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: phase_next = PH_TAIL;
                PH_ERR:  phase_next = PH_ERR;
                default: phase_next = PH_ERR;
            endcase
        end
    end

    // accumulators and result fields
    always_comb begin
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        if (take && byte_dig && acc_fits) begin
            if (phase_reg == PH_LEAD || phase_reg == PH_FIRST) begin
                first_acc_next = acc_step;
            end else if (phase_reg == PH_MID || phase_reg == PH_SECOND) begin
                second_acc_next = acc_step;
            end
        end

        if (phase_next == PH_LEAD) begin
            m_status_next = ST_EMPTY;
        end else if (phase_next == PH_SECOND || phase_next == PH_TAIL) begin
            m_status_next = ST_OK;
        end else begin
            m_status_next = ST_ERROR;
        end

        if (m_status_next == ST_OK) begin
            m_first_next  = OUT_WIDTH'(first_acc_next);
            m_second_next = OUT_WIDTH'(second_acc_next);
        end else begin
            m_first_next  = '0;
            m_second_next = '0;
        end

        m_valid_next = load_result ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEAD;
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            // drop the string state once its result is loaded
            if (load_result) begin
                phase_reg      <= PH_LEAD;
                first_acc_reg  <= '0;
                second_acc_reg <= '0;
            end else begin
                phase_reg      <= phase_next;
                first_acc_reg  <= first_acc_next;
                second_acc_reg <= second_acc_next;
            end
        end
        if (load_result) begin
            m_first_reg  <= m_first_next;
            m_second_reg <= m_second_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_value  = m_first_reg;
    assign m_second_value = m_second_reg;
    assign m_status       = m_status_reg;

endmodule

`default_nettype wire

// File: dv/tufp_result_check.sv
`timescale 1ns / 100ps

module tufp_result_check (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [7:0]                     s_ch,
    input  wire logic                           s_ch_valid,
    input  wire logic                           s_last,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [tufp_pkg::OUT_WIDTH-1:0] m_first_value,
    input  wire logic [tufp_pkg::OUT_WIDTH-1:0] m_second_value,
    input  wire logic [1:0]                     m_status,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    output int                                  n_fail,
    output int                                  n_pending
);
    import tufp_pkg::*;

    localparam int VW = VALUE_WIDTH;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_HT    = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] first_value;
        logic [OUT_WIDTH-1:0] second_value;
        status_t              status;
    } parse_result_t;

    phase_t        scan_phase = PH_LEAD;
    logic [VW-1:0] first_num  = '0;
    logic [VW-1:0] second_num = '0;
    parse_result_t expected_q[$];

    task automatic report_mismatch(input string msg);
        if (n_fail < 100)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_fail++;
    endtask

    // Advance the parse by one byte.
    task automatic scan_byte(input logic [7:0] c);
        logic          dig;
        logic          spc;
        logic [VW+3:0] grown;
        dig = (c >= CHR_0) && (c <= CHR_9);
        spc = (c == CHR_SPACE) || ((c >= CHR_HT) && (c <= CHR_CR));
        case (scan_phase)
            PH_LEAD, PH_MID: begin
                if (dig)
                    scan_phase = (scan_phase == PH_LEAD) ? PH_FIRST : PH_SECOND;
                else if (!spc)
                    scan_phase = PH_ERR;
            end
            PH_FIRST: begin
                if (!dig)
                    scan_phase = spc ? PH_MID : PH_ERR;
            end
            PH_SECOND: begin
                if (!dig)
                    scan_phase = PH_TAIL;
            end
            default: ;
        endcase
        // widen by four bits so that any carry past the top shows as overflow
        if (dig && (scan_phase == PH_FIRST || scan_phase == PH_SECOND)) begin
            grown = {4'b0000, (scan_phase == PH_FIRST) ? first_num : second_num} * 10
                    + (c - CHR_0);
            if (grown[VW+3:VW] != 4'd0)
                scan_phase = PH_ERR;
            else if (scan_phase == PH_FIRST)
                first_num = grown[VW-1:0];
            else
                second_num = grown[VW-1:0];
        end
    endtask

    always @(posedge aclk) begin : watch
        parse_result_t want;
        if (!aresetn) begin
            scan_phase = PH_LEAD;
            first_num  = '0;
            second_num = '0;
            expected_q.delete();
        end else begin
            // retire before predicting: a result never leaves on the edge of its last beat
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with no result expected");
                end else begin
                    want = expected_q.pop_front();
                    if (m_first_value !== want.first_value)
                        report_mismatch($sformatf("first_value got %0d want %0d",
                                                  m_first_value, want.first_value));
                    if (m_second_value !== want.second_value)
                        report_mismatch($sformatf("second_value got %0d want %0d",
                                                  m_second_value, want.second_value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_status, want.status));
                end
            end
            if (s_valid && s_ready) begin
                if (s_ch_valid)
                    scan_byte(s_ch);
                if (s_last) begin
                    if (scan_phase == PH_LEAD)
                        want.status = ST_EMPTY;
                    else if (scan_phase == PH_SECOND || scan_phase == PH_TAIL)
                        want.status = ST_OK;
                    else
                        want.status = ST_ERROR;
                    want.first_value  = '0;
                    want.second_value = '0;
                    if (want.status == ST_OK) begin
                        want.first_value  = first_num;
                        want.second_value = second_num;
                    end
                    expected_q.push_back(want);
                    scan_phase = PH_LEAD;
                    first_num  = '0;
                    second_num = '0;
                end
            end
        end
        n_pending = expected_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tufp_pkg::*;

    localparam int                     N_ITEMS   = 1750;
    localparam logic [VALUE_WIDTH-1:0] TOP_VALUE = '1;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic [7:0]           s_ch       = 8'h00;
    logic                 s_ch_valid = 1'b0;
    logic                 s_last     = 1'b0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic [OUT_WIDTH-1:0] m_first_value;
    logic [OUT_WIDTH-1:0] m_second_value;
    logic [1:0]           m_status;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;

    logic                 bursts_on  = 1'b1;
    int                   stall_left = 0;
    int                   n_beats    = 0;
    int                   n_fail;
    int                   n_pending;
    string                max_digits;
    logic [7:0]           line_q[$];

    two_uint64_decimal_field_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_ch           (s_ch),
        .s_ch_valid     (s_ch_valid),
        .s_last         (s_last),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_status       (m_status),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

    tufp_result_check u_result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_ch           (s_ch),
        .s_ch_valid     (s_ch_valid),
        .s_last         (s_last),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_status       (m_status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .n_fail         (n_fail),
        .n_pending      (n_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: stall in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic has_byte, input logic ends);
        int gap;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_ch       <= c;
        s_ch_valid <= has_byte;
        s_last     <= ends;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (has_byte || ends)
            n_beats++;
    endtask

    // Send the queued string; close it on its last byte or with an empty end beat.
    task automatic send_line(input bit end_marker);
        int n;
        n = line_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(line_q[i], 1'b1, !end_marker && i == n - 1);
        end
        if (end_marker || n == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
        line_q.delete();
    endtask

    function automatic void push_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            line_q.push_back(txt[i]);
    endfunction

    task automatic send_text(input string txt, input bit end_marker);
        push_text(txt);
        send_line(end_marker);
    endtask

    function automatic logic [7:0] ws_char();
        int unsigned pick;
        pick = $urandom_range(0, 6);
        return (pick > 4) ? 8'h20 : 8'h09 + 8'(pick);
    endfunction

    // Mostly short numbers, with a good share right at or just past the top value.
    function automatic string random_number();
        string digits;
        int    pos;
        digits = "";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                repeat ($urandom_range(1, 3))
                    digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
            end
            5, 6: begin
                repeat ($urandom_range(1, 21))
                    digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
            end
            7: digits = max_digits;
            8: begin
                digits = max_digits;
                pos    = $urandom_range(0, digits.len() - 1);
                if (digits[pos] == "9" || $urandom_range(0, 1) == 0)
                    digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
                else
                    digits[pos] = digits[pos] + 8'd1;
            end
            default: begin
                digits = max_digits;
                digits[digits.len() - 1] = 8'h30 + 8'($urandom_range(0, 9));
                repeat ($urandom_range(0, 2))
                    digits = {"0", digits};
            end
        endcase
        return digits;
    endfunction

    initial begin
        int kind;
        max_digits = $sformatf("%0d", TOP_VALUE);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("", 1'b1);
        send_text("\011\012\013\014\015 ", 1'b1);
        send_text("0 0", 1'b0);
        send_text("x1 2", 1'b0);
        send_text("5", 1'b1);
        send_text("1 2!", 1'b0);
        send_text("\377", 1'b0);
        send_text("9/", 1'b0);

        while (n_beats < N_ITEMS) begin
            bursts_on <= (n_beats < N_ITEMS * 85 / 100) && ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                repeat ($urandom_range(0, 2)) line_q.push_back(ws_char());
                push_text(random_number());
                repeat ($urandom_range(1, 2)) line_q.push_back(ws_char());
                push_text(random_number());
                repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom));
                // damage some: overwrite one byte, or cut the string short
                if (kind >= 75)
                    line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
                else if (kind >= 65)
                    repeat ($urandom_range(1, line_q.size() - 1)) void'(line_q.pop_back());
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(0, 4)) line_q.push_back(ws_char());
            end
            send_line($urandom_range(0, 3) == 0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("** two_uint64_decimal_field_parser: PASSED **");
        else
            $display("** two_uint64_decimal_field_parser: FAILED **");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("** two_uint64_decimal_field_parser: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tufp_pkg.sv
hw/rtl/tufp_digit_acc.sv
hw/rtl/two_uint64_decimal_field_parser.sv
dv/tufp_result_check.sv
dv/tb_top.sv
